/* src/cbtd_pkg.sv */
// ----------------------------------------------------------------------------
// cbtd_pkg: shared types and codes for the CBOR item token decoder
// Event record passed from the byte parser to the token formatter, queue
// status, token kinds and value type codes.
// ----------------------------------------------------------------------------
package cbtd_pkg;

    // event codes carried through the queue
    localparam logic [1:0] EV_HDR = 2'd0;
    localparam logic [1:0] EV_PAY = 2'd1;
    localparam logic [1:0] EV_BAD = 2'd2;

    // token kinds
    localparam logic [3:0] K_UINT    = 4'd0;
    localparam logic [3:0] K_NEG     = 4'd1;
    localparam logic [3:0] K_BYTES   = 4'd2;
    localparam logic [3:0] K_TEXT    = 4'd3;
    localparam logic [3:0] K_PAYLOAD = 4'd4;
    localparam logic [3:0] K_ARRAY   = 4'd5;
    localparam logic [3:0] K_MAP     = 4'd6;
    localparam logic [3:0] K_TAG     = 4'd7;
    localparam logic [3:0] K_FALSE   = 4'd8;
    localparam logic [3:0] K_TRUE    = 4'd9;
    localparam logic [3:0] K_NULL    = 4'd10;
    localparam logic [3:0] K_UNDEF   = 4'd11;
    localparam logic [3:0] K_F32     = 4'd12;
    localparam logic [3:0] K_F64     = 4'd13;
    localparam logic [3:0] K_SKIP    = 4'd14;
    localparam logic [3:0] K_BAD     = 4'd15;

    // value types
    localparam logic [3:0] VT_NONE = 4'd0;
    localparam logic [3:0] VT_U8   = 4'd1;
    localparam logic [3:0] VT_U16  = 4'd2;
    localparam logic [3:0] VT_U32  = 4'd3;
    localparam logic [3:0] VT_U64  = 4'd4;
    localparam logic [3:0] VT_I8   = 4'd5;
    localparam logic [3:0] VT_I16  = 4'd6;
    localparam logic [3:0] VT_I32  = 4'd7;
    localparam logic [3:0] VT_I64  = 4'd8;

    // major types
    localparam logic [2:0] MJ_UINT  = 3'd0;
    localparam logic [2:0] MJ_NEG   = 3'd1;
    localparam logic [2:0] MJ_BYTES = 3'd2;
    localparam logic [2:0] MJ_TEXT  = 3'd3;
    localparam logic [2:0] MJ_ARRAY = 3'd4;
    localparam logic [2:0] MJ_MAP   = 3'd5;
    localparam logic [2:0] MJ_TAG   = 3'd6;
    localparam logic [2:0] MJ_SIMPLE = 3'd7;

    // minor codes
    localparam logic [4:0] MN_ARG1   = 5'd24;
    localparam logic [4:0] MN_ARG2   = 5'd25;
    localparam logic [4:0] MN_ARG4   = 5'd26;
    localparam logic [4:0] MN_ARG8   = 5'd27;
    localparam logic [4:0] MN_FALSE  = 5'd20;
    localparam logic [4:0] MN_TRUE   = 5'd21;
    localparam logic [4:0] MN_NULL   = 5'd22;
    localparam logic [4:0] MN_UNDEF  = 5'd23;

    typedef struct packed {
        logic [1:0]  ev;
        logic [2:0]  major;
        logic [4:0]  minor;
        logic [63:0] arg;
        logic [7:0]  pbyte;
    } t_event;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_status;

endpackage

/* src/cbtd_front.sv */
// ----------------------------------------------------------------------------
// cbtd_front: CBOR byte parser
// Splits header bytes, collects big-endian arguments and counts string
// payload bytes; pushes one event per finished token into the queue.
// ----------------------------------------------------------------------------
module cbtd_front #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    output logic                o_push,
    output cbtd_pkg::t_event    o_event
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_ARG     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [63:0] LenMax = {64{1'b1}} >> (64 - LENGTH_BITS);

    logic [1:0]             r_phase, n_phase;
    logic [2:0]             r_major, n_major;
    logic [4:0]             r_minor, n_minor;
    logic [63:0]            r_accum, n_accum;
    logic [3:0]             r_left, n_left;
    logic [LENGTH_BITS-1:0] r_pl, n_pl;

    logic                   push;
    cbtd_pkg::t_event       ev;
    logic [2:0]             hdr_major;
    logic [63:0]            hdr_arg;
    logic                   hdr_done;

    always_comb begin
        n_phase   = r_phase;
        n_major   = r_major;
        n_minor   = r_minor;
        n_accum   = r_accum;
        n_left    = r_left;
        n_pl      = r_pl;
        push      = 1'b0;
        hdr_done  = 1'b0;
        hdr_major = r_major;
        hdr_arg   = r_accum;
        ev        = '0;
        unique case (r_phase)
            PH_ARG: begin
                n_accum = {r_accum[55:0], i_data_byte};
                n_left  = r_left - 4'd1;
                if (n_left == 4'd0) begin
                    hdr_done = 1'b1;
                    hdr_arg  = n_accum;
                    n_phase  = PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                n_pl     = r_pl - LENGTH_BITS'(1);
                push     = 1'b1;
                ev.ev    = cbtd_pkg::EV_PAY;
                ev.arg   = 64'(n_pl);
                ev.pbyte = i_data_byte;
                if (n_pl == '0) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
                n_major   = i_data_byte[7:5];
                n_minor   = i_data_byte[4:0];
                hdr_major = i_data_byte[7:5];
                n_phase   = PH_HEADER;
                if (i_data_byte[4:0] < cbtd_pkg::MN_ARG1) begin
                    n_accum  = 64'(i_data_byte[4:0]);
                    hdr_arg  = 64'(i_data_byte[4:0]);
                    hdr_done = 1'b1;
                end else if (i_data_byte[4:0] <= cbtd_pkg::MN_ARG8) begin
                    n_accum = '0;
                    n_phase = PH_ARG;
                    case (i_data_byte[1:0])
                        2'd0:    n_left = 4'd1;
                        2'd1:    n_left = 4'd2;
                        2'd2:    n_left = 4'd4;
                        default: n_left = 4'd8;
                    endcase
                end else begin
                    push     = 1'b1;
                    ev.ev    = cbtd_pkg::EV_BAD;
                    ev.minor = i_data_byte[4:0];
                    ev.arg   = 64'(i_data_byte[4:0]);
                end
            end
        endcase
        if (hdr_done) begin
            push     = 1'b1;
            ev.ev    = cbtd_pkg::EV_HDR;
            ev.major = hdr_major;
            ev.minor = n_minor;
            ev.arg   = hdr_arg;
            if ((hdr_major == cbtd_pkg::MJ_BYTES || hdr_major == cbtd_pkg::MJ_TEXT)
                && hdr_arg != 64'd0 && hdr_arg <= LenMax) begin
                n_phase = PH_PAYLOAD;
                n_pl    = hdr_arg[LENGTH_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_major <= '0;
            r_minor <= '0;
            r_accum <= '0;
            r_left  <= '0;
            r_pl    <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_major <= n_major;
            r_minor <= n_minor;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_pl    <= n_pl;
        end
    end

    assign o_push  = i_accept && push;
    assign o_event = ev;

    a_arg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ARG |-> r_left != 4'd0)
        else $error("argument phase with no bytes left");

    a_pay_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_pl != '0)
        else $error("payload phase with zero count");

endmodule

/* src/cbtd_fifo.sv */
// ----------------------------------------------------------------------------
// cbtd_fifo: two-entry event queue
// Decouples the byte parser from the token formatter; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module cbtd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cbtd_pkg::t_event     i_wdata,
    input  logic                 i_pop,
    output cbtd_pkg::t_event     o_rdata,
    output cbtd_pkg::t_q_status  o_status
);

    cbtd_pkg::t_event r_mem [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    assign o_rdata           = r_mem[r_rp];
    assign o_status.full     = (r_cnt == 2'd2);
    assign o_status.nonempty = (r_cnt != 2'd0);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_cnt != 2'd2)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != 2'd0)
        else $error("pop from empty queue");

endmodule

/* src/cbtd_back.sv */
// ----------------------------------------------------------------------------
// cbtd_back: token formatter
// Maps a queued event to token kind, value type and end-of-item flag and
// holds it in the output register until the transaction completes.
// ----------------------------------------------------------------------------
module cbtd_back #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cbtd_pkg::t_q_status  i_status,
    input  cbtd_pkg::t_event     i_event,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [3:0]           o_token_kind,
    output logic [63:0]          o_argument,
    output logic [3:0]           o_value_type,
    output logic [7:0]           o_payload_byte,
    output logic                 o_ends_item
);

    localparam logic [63:0] LenMax = {64{1'b1}} >> (64 - LENGTH_BITS);

    logic        r_valid;
    logic [3:0]  r_kind, n_kind;
    logic [63:0] r_arg, n_arg;
    logic [3:0]  r_vt, n_vt;
    logic [7:0]  r_pb, n_pb;
    logic        r_ends, n_ends;
    logic        load;
    logic        a_zero;

    assign load   = !r_valid || !i_stall;
    assign o_pop  = load && i_status.nonempty;
    assign a_zero = (i_event.arg == 64'd0);

    always_comb begin
        n_kind = cbtd_pkg::K_BAD;
        n_arg  = i_event.arg;
        n_vt   = cbtd_pkg::VT_NONE;
        n_pb   = 8'd0;
        n_ends = 1'b1;
        unique case (i_event.ev)
            cbtd_pkg::EV_PAY: begin
                n_kind = cbtd_pkg::K_PAYLOAD;
                n_pb   = i_event.pbyte;
                n_ends = a_zero;
            end
            cbtd_pkg::EV_HDR: begin
                unique case (i_event.major)
                    cbtd_pkg::MJ_UINT: begin
                        n_kind = cbtd_pkg::K_UINT;
                        if (i_event.minor <= cbtd_pkg::MN_ARG1)     n_vt = cbtd_pkg::VT_U8;
                        else if (i_event.minor == cbtd_pkg::MN_ARG2) n_vt = cbtd_pkg::VT_U16;
                        else if (i_event.minor == cbtd_pkg::MN_ARG4) n_vt = cbtd_pkg::VT_U32;
                        else                                         n_vt = cbtd_pkg::VT_U64;
                    end
                    cbtd_pkg::MJ_NEG: begin
                        n_kind = cbtd_pkg::K_NEG;
                        if (i_event.minor < cbtd_pkg::MN_ARG1) begin
                            n_vt = cbtd_pkg::VT_I8;
                        end else if (i_event.minor == cbtd_pkg::MN_ARG1) begin
                            n_vt = (i_event.arg <= 64'd127) ? cbtd_pkg::VT_I8
                                                            : cbtd_pkg::VT_I16;
                        end else if (i_event.minor == cbtd_pkg::MN_ARG2) begin
                            n_vt = (i_event.arg < 64'd32767) ? cbtd_pkg::VT_I16
                                                             : cbtd_pkg::VT_I32;
                        end else if (i_event.minor == cbtd_pkg::MN_ARG4) begin
                            n_vt = (i_event.arg <= 64'h7FFF_FFFF) ? cbtd_pkg::VT_I32
                                                                  : cbtd_pkg::VT_I64;
                        end else begin
                            n_vt = cbtd_pkg::VT_I64;
                        end
                    end
                    cbtd_pkg::MJ_BYTES, cbtd_pkg::MJ_TEXT: begin
                        if (i_event.arg > LenMax) begin
                            n_kind = cbtd_pkg::K_BAD;
                        end else begin
                            n_kind = {1'b0, i_event.major};
                            n_ends = a_zero;
                        end
                    end
                    cbtd_pkg::MJ_ARRAY: begin
                        n_kind = cbtd_pkg::K_ARRAY;
                        n_ends = a_zero;
                    end
                    cbtd_pkg::MJ_MAP: begin
                        n_kind = cbtd_pkg::K_MAP;
                        n_ends = a_zero;
                    end
                    cbtd_pkg::MJ_TAG: begin
                        n_kind = cbtd_pkg::K_TAG;
                        n_ends = 1'b0;
                    end
                    default: begin
                        unique case (i_event.minor)
                            cbtd_pkg::MN_FALSE: n_kind = cbtd_pkg::K_FALSE;
                            cbtd_pkg::MN_TRUE:  n_kind = cbtd_pkg::K_TRUE;
                            cbtd_pkg::MN_NULL:  n_kind = cbtd_pkg::K_NULL;
                            cbtd_pkg::MN_UNDEF: n_kind = cbtd_pkg::K_UNDEF;
                            cbtd_pkg::MN_ARG4: begin
                                n_kind = cbtd_pkg::K_F32;
                                n_arg  = {32'd0, i_event.arg[31:0]};
                            end
                            cbtd_pkg::MN_ARG8:  n_kind = cbtd_pkg::K_F64;
                            default:            n_kind = cbtd_pkg::K_SKIP;
                        endcase
                    end
                endcase
            end
            default: begin
                n_kind = cbtd_pkg::K_BAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_status.nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind <= n_kind;
            r_arg  <= n_arg;
            r_vt   <= n_vt;
            r_pb   <= n_pb;
            r_ends <= n_ends;
        end
    end

    assign o_valid        = r_valid;
    assign o_token_kind   = r_kind;
    assign o_argument     = r_arg;
    assign o_value_type   = r_vt;
    assign o_payload_byte = r_pb;
    assign o_ends_item    = r_ends;

endmodule

/* src/cbor_item_token_decoder.sv */
// ----------------------------------------------------------------------------
// cbor_item_token_decoder: byte-serial CBOR token decoder
// Throughput: one byte per cycle sustained; stalls input only when the
// two-entry event queue is full.
// Path: byte parser, event queue, output register; a token's event is queued
// when its last byte is accepted and leaves once the output register is free.
// Reset: synchronous active-low; parser returns to header phase, queue and
// output register empty.
// ----------------------------------------------------------------------------
module cbor_item_token_decoder #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [63:0] o_argument,
    output logic [3:0]  o_value_type,
    output logic [7:0]  o_payload_byte,
    output logic        o_ends_item
);

    logic                accept;
    logic                push;
    logic                pop;
    cbtd_pkg::t_event    wr_event;
    cbtd_pkg::t_event    rd_event;
    cbtd_pkg::t_q_status q_status;

    assign o_stall = q_status.full;
    assign accept  = i_valid && !q_status.full;

    cbtd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_event     (wr_event)
    );

    cbtd_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_wdata  (wr_event),
        .i_pop    (pop),
        .o_rdata  (rd_event),
        .o_status (q_status)
    );

    cbtd_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_status       (q_status),
        .i_event        (rd_event),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_token_kind   (o_token_kind),
        .o_argument     (o_argument),
        .o_value_type   (o_value_type),
        .o_payload_byte (o_payload_byte),
        .o_ends_item    (o_ends_item)
    );

endmodule

/* tb/sv/cbor_token_checker.sv */
// ----------------------------------------------------------------------------
// cbor_token_checker: token predictor and scoreboard for the CBOR decoder
// Watches the byte and token channels. Each accepted byte is run through a
// local copy of the header/argument/payload parser and the tokens it yields
// are queued; each accepted token is compared field by field with the oldest
// queued one.
// ----------------------------------------------------------------------------
module cbor_token_checker #(
    parameter int LENGTH_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_stall,
    input  logic [7:0]  i_byte,
    input  logic        i_tok_valid,
    input  logic        i_tok_stall,
    input  logic [3:0]  i_kind,
    input  logic [63:0] i_arg,
    input  logic [3:0]  i_vt,
    input  logic [7:0]  i_pbyte,
    input  logic        i_ends,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [63:0] LEN_MAX =
        (LENGTH_BITS >= 64) ? '1 : ((64'd1 << LENGTH_BITS) - 64'd1);

    typedef enum logic [1:0] {
        EXPECT_HEADER,
        COLLECT_ARG,
        IN_PAYLOAD
    } t_parse_phase;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] arg;
        logic [3:0]  vt;
        logic [7:0]  pbyte;
        logic        ends;
    } t_token;

    t_token       expected_tokens[$];
    int           fail_total = 0;

    t_parse_phase phase;
    logic [2:0]   major_kind;
    logic [4:0]   minor_code;
    logic [63:0]  arg_accum;
    logic [3:0]   arg_bytes_left;
    logic [63:0]  payload_left;

    task report_mismatch(input string what, input logic [63:0] got,
                         input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_total++;
    endtask

    task push_token(input logic [3:0] kind, input logic [63:0] arg,
                    input logic [3:0] vt, input logic [7:0] pbyte,
                    input logic ends);
        t_token t;
        t.kind  = kind;
        t.arg   = arg;
        t.vt    = vt;
        t.pbyte = pbyte;
        t.ends  = ends;
        expected_tokens.push_back(t);
    endtask

    function automatic logic [3:0] uint_width(input logic [4:0] mn);
        if (mn <= cbtd_pkg::MN_ARG1) return cbtd_pkg::VT_U8;
        if (mn == cbtd_pkg::MN_ARG2) return cbtd_pkg::VT_U16;
        if (mn == cbtd_pkg::MN_ARG4) return cbtd_pkg::VT_U32;
        return cbtd_pkg::VT_U64;
    endfunction

    function automatic logic [3:0] negint_width(input logic [4:0] mn,
                                                input logic [63:0] a);
        if (mn < cbtd_pkg::MN_ARG1) return cbtd_pkg::VT_I8;
        if (mn == cbtd_pkg::MN_ARG1)
            return (a <= 64'd127) ? cbtd_pkg::VT_I8 : cbtd_pkg::VT_I16;
        if (mn == cbtd_pkg::MN_ARG2)
            return (a < 64'd32767) ? cbtd_pkg::VT_I16 : cbtd_pkg::VT_I32;
        if (mn == cbtd_pkg::MN_ARG4)
            return (a <= 64'h7FFF_FFFF) ? cbtd_pkg::VT_I32 : cbtd_pkg::VT_I64;
        return cbtd_pkg::VT_I64;
    endfunction

    task finish_header(input logic [63:0] a);
        phase = EXPECT_HEADER;
        case (major_kind)
            cbtd_pkg::MJ_UINT:
                push_token(cbtd_pkg::K_UINT, a, uint_width(minor_code), 8'd0, 1'b1);
            cbtd_pkg::MJ_NEG:
                push_token(cbtd_pkg::K_NEG, a, negint_width(minor_code, a), 8'd0, 1'b1);
            cbtd_pkg::MJ_BYTES, cbtd_pkg::MJ_TEXT: begin
                if (a > LEN_MAX) begin
                    push_token(cbtd_pkg::K_BAD, a, cbtd_pkg::VT_NONE, 8'd0, 1'b1);
                end else if (a == 64'd0) begin
                    push_token((major_kind == cbtd_pkg::MJ_BYTES) ? cbtd_pkg::K_BYTES
                                                                  : cbtd_pkg::K_TEXT,
                               64'd0, cbtd_pkg::VT_NONE, 8'd0, 1'b1);
                end else begin
                    payload_left = a;
                    phase = IN_PAYLOAD;
                    push_token((major_kind == cbtd_pkg::MJ_BYTES) ? cbtd_pkg::K_BYTES
                                                                  : cbtd_pkg::K_TEXT,
                               a, cbtd_pkg::VT_NONE, 8'd0, 1'b0);
                end
            end
            cbtd_pkg::MJ_ARRAY:
                push_token(cbtd_pkg::K_ARRAY, a, cbtd_pkg::VT_NONE, 8'd0, a == 64'd0);
            cbtd_pkg::MJ_MAP:
                push_token(cbtd_pkg::K_MAP, a, cbtd_pkg::VT_NONE, 8'd0, a == 64'd0);
            cbtd_pkg::MJ_TAG:
                push_token(cbtd_pkg::K_TAG, a, cbtd_pkg::VT_NONE, 8'd0, 1'b0);
            default: begin
                case (minor_code)
                    cbtd_pkg::MN_FALSE:
                        push_token(cbtd_pkg::K_FALSE, a, cbtd_pkg::VT_NONE, 8'd0, 1'b1);
                    cbtd_pkg::MN_TRUE:
                        push_token(cbtd_pkg::K_TRUE, a, cbtd_pkg::VT_NONE, 8'd0, 1'b1);
                    cbtd_pkg::MN_NULL:
                        push_token(cbtd_pkg::K_NULL, a, cbtd_pkg::VT_NONE, 8'd0, 1'b1);
                    cbtd_pkg::MN_UNDEF:
                        push_token(cbtd_pkg::K_UNDEF, a, cbtd_pkg::VT_NONE, 8'd0, 1'b1);
                    cbtd_pkg::MN_ARG4:
                        push_token(cbtd_pkg::K_F32, {32'd0, a[31:0]}, cbtd_pkg::VT_NONE,
                                   8'd0, 1'b1);
                    cbtd_pkg::MN_ARG8:
                        push_token(cbtd_pkg::K_F64, a, cbtd_pkg::VT_NONE, 8'd0, 1'b1);
                    default:
                        push_token(cbtd_pkg::K_SKIP, a, cbtd_pkg::VT_NONE, 8'd0, 1'b1);
                endcase
            end
        endcase
    endtask

    task decode_byte(input logic [7:0] b);
        case (phase)
            COLLECT_ARG: begin
                arg_accum = {arg_accum[55:0], b};
                arg_bytes_left = arg_bytes_left - 4'd1;
                if (arg_bytes_left == 4'd0)
                    finish_header(arg_accum);
            end
            IN_PAYLOAD: begin
                payload_left = (payload_left - 64'd1) & LEN_MAX;
                push_token(cbtd_pkg::K_PAYLOAD, payload_left, cbtd_pkg::VT_NONE, b,
                           payload_left == 64'd0);
                if (payload_left == 64'd0)
                    phase = EXPECT_HEADER;
            end
            default: begin
                major_kind = b[7:5];
                minor_code = b[4:0];
                if (minor_code < cbtd_pkg::MN_ARG1) begin
                    arg_accum = {59'd0, minor_code};
                    finish_header(arg_accum);
                end else if (minor_code <= cbtd_pkg::MN_ARG8) begin
                    arg_accum = 64'd0;
                    arg_bytes_left = 4'd1 << (minor_code - cbtd_pkg::MN_ARG1);
                    phase = COLLECT_ARG;
                end else begin
                    // reserved or indefinite minor
                    phase = EXPECT_HEADER;
                    push_token(cbtd_pkg::K_BAD, {59'd0, minor_code}, cbtd_pkg::VT_NONE,
                               8'd0, 1'b1);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin : track
        t_token want;
        if (!i_rst_n) begin
            phase          = EXPECT_HEADER;
            major_kind     = '0;
            minor_code     = '0;
            arg_accum      = '0;
            arg_bytes_left = '0;
            payload_left   = '0;
            expected_tokens.delete();
        end else begin
            if (i_tok_valid && !i_tok_stall) begin
                if (expected_tokens.size() == 0) begin
                    report_mismatch("token with none expected", {60'd0, i_kind}, 64'd0);
                end else begin
                    want = expected_tokens.pop_front();
                    if (i_kind !== want.kind)
                        report_mismatch("token_kind", {60'd0, i_kind}, {60'd0, want.kind});
                    if (i_arg !== want.arg)
                        report_mismatch("argument", i_arg, want.arg);
                    if (i_vt !== want.vt)
                        report_mismatch("value_type", {60'd0, i_vt}, {60'd0, want.vt});
                    if (i_pbyte !== want.pbyte)
                        report_mismatch("payload_byte", {56'd0, i_pbyte}, {56'd0, want.pbyte});
                    if (i_ends !== want.ends)
                        report_mismatch("ends_item", {63'd0, i_ends}, {63'd0, want.ends});
                end
            end
            if (i_byte_valid && !i_byte_stall)
                decode_byte(i_byte);
        end
        o_pending    <= expected_tokens.size();
        o_fail_count <= fail_total;
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: CBOR item token decoder regression
// Feeds a directed set of headers covering every major type, argument width
// and edge case, then a long random stream of mostly well-formed items with
// some noise bytes, under random source gaps and sink stalls. The checker
// predicts and compares every token; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_BYTES = 1700;
    localparam int CYCLE_LIMIT  = 500000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_stall     = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [63:0] o_argument;
    logic [3:0]  o_value_type;
    logic [7:0]  o_payload_byte;
    logic        o_ends_item;

    int          fail_count;
    int          pending_tokens;
    int          cycle_count = 0;
    int          tx_max_gap  = 0;
    int          rx_max_gap  = 0;
    int          rx_hold     = 0;
    logic [7:0]  byte_stream[$];

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    cbor_item_token_decoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_argument     (o_argument),
        .o_value_type   (o_value_type),
        .o_payload_byte (o_payload_byte),
        .o_ends_item    (o_ends_item)
    );

    cbor_token_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (i_valid),
        .i_byte_stall (o_stall),
        .i_byte       (i_data_byte),
        .i_tok_valid  (o_valid),
        .i_tok_stall  (i_stall),
        .i_kind       (o_token_kind),
        .i_arg        (o_argument),
        .i_vt         (o_value_type),
        .i_pbyte      (o_payload_byte),
        .i_ends       (o_ends_item),
        .o_fail_count (fail_count),
        .o_pending    (pending_tokens)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // sink: stall for a random number of cycles after each transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold = 0;
            i_stall <= 1'b0;
        end else if (o_valid && !i_stall) begin
            rx_hold = $urandom_range(0, rx_max_gap);
            i_stall <= (rx_hold != 0);
        end else if (rx_hold != 0) begin
            rx_hold--;
            i_stall <= (rx_hold != 0);
        end
    end

    task emit_header(input logic [2:0] mj, input logic [4:0] mn, input logic [63:0] v);
        int n;
        byte_stream.push_back({mj, mn});
        if (mn >= cbtd_pkg::MN_ARG1 && mn <= cbtd_pkg::MN_ARG8) begin
            n = 1 << (mn - cbtd_pkg::MN_ARG1);
            for (int j = n - 1; j >= 0; j--)
                byte_stream.push_back(v[8*j +: 8]);
        end
    endtask

    function automatic logic [63:0] pick_value(input logic [4:0] mn);
        logic [63:0] v;
        int          bits;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = 64'd0;
            1: v = '1;
            2: v = 64'd127;
            3: v = 64'd128;
            4: v = 64'd32766;
            5: v = 64'd32767;
            6: v = 64'h7FFF_FFFF;
            7: v = 64'h8000_0000;
            8: v = {1'b1, 63'd0};
            default: ;
        endcase
        bits = 8 << (mn - cbtd_pkg::MN_ARG1);
        if (bits < 64)
            v = v & ((64'd1 << bits) - 64'd1);
        return v;
    endfunction

    task build_directed();
        emit_header(cbtd_pkg::MJ_UINT, 5'd0, 64'd0);
        emit_header(cbtd_pkg::MJ_UINT, 5'd23, 64'd23);
        emit_header(cbtd_pkg::MJ_UINT, cbtd_pkg::MN_ARG1, 64'hFF);
        emit_header(cbtd_pkg::MJ_UINT, cbtd_pkg::MN_ARG8, '1);
        emit_header(cbtd_pkg::MJ_NEG, 5'd0, 64'd0);
        emit_header(cbtd_pkg::MJ_NEG, cbtd_pkg::MN_ARG1, 64'd127);
        emit_header(cbtd_pkg::MJ_NEG, cbtd_pkg::MN_ARG1, 64'd128);
        emit_header(cbtd_pkg::MJ_NEG, cbtd_pkg::MN_ARG2, 64'd32766);
        emit_header(cbtd_pkg::MJ_NEG, cbtd_pkg::MN_ARG2, 64'd32767);
        emit_header(cbtd_pkg::MJ_NEG, cbtd_pkg::MN_ARG4, 64'h7FFF_FFFF);
        emit_header(cbtd_pkg::MJ_NEG, cbtd_pkg::MN_ARG4, 64'h8000_0000);
        emit_header(cbtd_pkg::MJ_NEG, cbtd_pkg::MN_ARG8, '1);
        emit_header(cbtd_pkg::MJ_BYTES, 5'd0, 64'd0);
        emit_header(cbtd_pkg::MJ_TEXT, 5'd2, 64'd2);
        byte_stream.push_back(8'h00);
        byte_stream.push_back(8'hFF);
        emit_header(cbtd_pkg::MJ_BYTES, cbtd_pkg::MN_ARG8, 64'h1_0000_0000);
        emit_header(cbtd_pkg::MJ_ARRAY, 5'd0, 64'd0);
        emit_header(cbtd_pkg::MJ_MAP, cbtd_pkg::MN_ARG2, 64'hFFFF);
        emit_header(cbtd_pkg::MJ_TAG, cbtd_pkg::MN_ARG4, 64'hDEAD_BEEF);
        for (int m = cbtd_pkg::MN_FALSE; m <= cbtd_pkg::MN_UNDEF; m++)
            emit_header(cbtd_pkg::MJ_SIMPLE, m[4:0], 64'd0);
        emit_header(cbtd_pkg::MJ_SIMPLE, 5'd0, 64'd0);
        emit_header(cbtd_pkg::MJ_SIMPLE, cbtd_pkg::MN_ARG1, 64'hFF);
        emit_header(cbtd_pkg::MJ_SIMPLE, cbtd_pkg::MN_ARG2, 64'h3C00);
        emit_header(cbtd_pkg::MJ_SIMPLE, cbtd_pkg::MN_ARG4, 64'h7F80_0000);
        emit_header(cbtd_pkg::MJ_SIMPLE, cbtd_pkg::MN_ARG8, 64'hFFF0_0000_0000_0001);
        byte_stream.push_back({cbtd_pkg::MJ_UINT, 5'd28});
        byte_stream.push_back({cbtd_pkg::MJ_TEXT, 5'd31});
        byte_stream.push_back({cbtd_pkg::MJ_SIMPLE, 5'd31});
    endtask

    task gen_item();
        logic [2:0]  mj;
        logic [4:0]  mn;
        logic [63:0] len;
        int          form;
        mj   = 3'($urandom_range(0, 7));
        form = $urandom_range(0, 99);
        if (form < 45)
            mn = 5'($urandom_range(0, 23));
        else if (form < 92)
            mn = 5'($urandom_range(24, 27));
        else
            mn = 5'($urandom_range(28, 31));
        if (mn > cbtd_pkg::MN_ARG8) begin
            byte_stream.push_back({mj, mn});
        end else if (mj == cbtd_pkg::MJ_BYTES || mj == cbtd_pkg::MJ_TEXT) begin
            if (mn < cbtd_pkg::MN_ARG1)
                len = {59'd0, mn};
            else if (mn == cbtd_pkg::MN_ARG8 && $urandom_range(0, 3) == 0)
                len = {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
            else
                len = 64'($urandom_range(0, 12));
            emit_header(mj, mn, len);
            if (len <= 64'hFFFF_FFFF)
                repeat (len[31:0]) byte_stream.push_back(8'($urandom_range(0, 255)));
        end else begin
            emit_header(mj, mn, (mn < cbtd_pkg::MN_ARG1) ? {59'd0, mn} : pick_value(mn));
        end
    endtask

    function automatic int pick_gap_limit();
        case ($urandom_range(0, 3))
            0, 1: return 0;
            2: return 16;
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    initial begin
        int gap;
        int target;
        build_directed();
        target = byte_stream.size() + RANDOM_BYTES;
        while (byte_stream.size() < target) begin
            if ($urandom_range(0, 99) < 12)
                byte_stream.push_back(8'($urandom_range(0, 255)));
            else
                gen_item();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < byte_stream.size(); k++) begin
            if (k % 128 == 0) begin
                tx_max_gap = pick_gap_limit();
                rx_max_gap <= pick_gap_limit();
            end
            gap = $urandom_range(0, tx_max_gap);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid     <= 1'b1;
            i_data_byte <= byte_stream[k];
            do @(posedge i_clk); while (o_stall);
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_tokens != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending_tokens == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
